### rtl/core/uac2_pkg.sv
// shared types, codes and defaults for the uac2 control request responder
// no dependencies; imported by every module of the block
package uac2_pkg;

    // request and response payloads
    typedef struct packed {
        logic        func;
        logic [7:0]  entity_id;
        logic [7:0]  control_selector;
        logic [7:0]  request_code;
        logic [7:0]  channel_number;
        logic [15:0] data_length;
        logic [15:0] set_data;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] reply_byte;
        logic       last;
    } t_rsp;

    // response status codes
    localparam logic [1:0] ST_BYTE  = 2'd0;
    localparam logic [1:0] ST_OK    = 2'd1;
    localparam logic [1:0] ST_STALL = 2'd2;

    // request fields
    localparam logic       FUNC_GET    = 1'b0;
    localparam logic [7:0] REQ_CUR     = 8'd1;
    localparam logic [7:0] REQ_RANGE   = 8'd2;
    localparam logic [7:0] SEL_FREQ    = 8'd1;
    localparam logic [7:0] SEL_VALID   = 8'd2;
    localparam logic [7:0] SEL_MUTE    = 8'd1;
    localparam logic [7:0] SEL_VOLUME  = 8'd2;
    localparam logic [15:0] LEN_MUTE   = 16'd1;
    localparam logic [15:0] LEN_VOLUME = 16'd2;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_ENTITY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FEATURE_ENTITY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_MIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_MAX     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_STEP    = 3'd5;

    // configuration defaults
    localparam logic [7:0]  RST_CLOCK_ENTITY   = 8'd4;
    localparam logic [7:0]  RST_FEATURE_ENTITY = 8'd2;
    localparam logic [31:0] RST_SAMPLE_RATE    = 32'd48000;
    localparam logic [15:0] RST_VOLUME_MIN     = 16'(-12800);
    localparam logic [15:0] RST_VOLUME_MAX     = 16'd0;
    localparam logic [15:0] RST_VOLUME_STEP    = 16'd256;

    localparam int unsigned DEF_CHANNELS = 2;

    // reply buffer
    localparam int unsigned REPLY_BYTES = 14;
    localparam int unsigned BYTE_IDX_W  = $clog2(REPLY_BYTES);

    // decoded request kind
    typedef enum logic [3:0] {
        K_STALL,
        K_SET_MUTE,
        K_SET_VOL,
        K_CLK_CUR,
        K_CLK_RANGE,
        K_CLK_VALID,
        K_MUTE_CUR,
        K_VOL_CUR,
        K_VOL_RANGE
    } t_kind;

    // controller to datapath commands
    typedef struct packed {
        logic load;   // capture request
        logic read;   // store read and set commit
        logic build;  // load first result
        logic next;   // load following result
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic last;   // result on the output is the final one
    } t_dp_stat;

    // number of results for a request kind
    function automatic logic [BYTE_IDX_W-1:0] kind_len(input t_kind k);
        logic [BYTE_IDX_W-1:0] n;
        case (k)
            K_CLK_CUR:   n = BYTE_IDX_W'(4);
            K_CLK_RANGE: n = BYTE_IDX_W'(14);
            K_VOL_CUR:   n = BYTE_IDX_W'(2);
            K_VOL_RANGE: n = BYTE_IDX_W'(8);
            default:     n = BYTE_IDX_W'(1);
        endcase
        return n;
    endfunction

endpackage

### rtl/core/uac2_ctrl.sv
// sequencing state machine for the uac2 responder
// depends on uac2_pkg; drives commands into uac2_dp
module uac2_ctrl import uac2_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    output logic     o_req_ready,
    output logic     o_rsp_valid,
    input  logic     i_rsp_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_LOAD = 4'b0100,
        S_SEND = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   w_acc;
    logic   w_out;

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = (r_state == S_SEND);
    assign w_acc       = i_req_valid && o_req_ready;
    assign w_out       = o_rsp_valid && i_rsp_ready;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.build = 1'b1;
                n_state     = S_SEND;
            end
            S_SEND: begin
                if (w_out) begin
                    if (i_stat.last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.next = 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/core/uac2_dp.sv
// datapath: configuration registers, channel stores, decode and reply serializer
// depends on uac2_pkg; commanded by uac2_ctrl
module uac2_dp import uac2_pkg::*; #(
    parameter int unsigned CHANNELS = DEF_CHANNELS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  t_req                 i_req,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    output t_rsp                 o_rsp
);

    localparam int unsigned DEPTH = CHANNELS + 1;
    localparam int unsigned CH_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // configuration registers
    logic [7:0]  r_clock_entity;
    logic [7:0]  r_feature_entity;
    logic [31:0] r_sample_rate;
    logic [15:0] r_volume_min;
    logic [15:0] r_volume_max;
    logic [15:0] r_volume_step;

    // request and stores
    t_req             r_req;
    logic [7:0]       mute_mem [DEPTH];
    logic [15:0]      vol_mem  [DEPTH];
    logic [DEPTH-1:0] r_mute_vld;
    logic [DEPTH-1:0] r_vol_vld;
    logic [7:0]       r_mute_rd;
    logic [15:0]      r_vol_rd;

    // serializer
    t_rsp                  r_rsp;
    logic [BYTE_IDX_W-1:0] r_idx;

    logic                       w_ch_ok;
    logic [CH_W-1:0]            w_ch;
    t_kind                      w_kind;
    logic [BYTE_IDX_W-1:0]      w_len;
    logic [BYTE_IDX_W-1:0]      w_sel;
    logic [REPLY_BYTES*8-1:0]   w_buf;
    t_rsp                       w_rsp;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_entity   <= RST_CLOCK_ENTITY;
            r_feature_entity <= RST_FEATURE_ENTITY;
            r_sample_rate    <= RST_SAMPLE_RATE;
            r_volume_min     <= RST_VOLUME_MIN;
            r_volume_max     <= RST_VOLUME_MAX;
            r_volume_step    <= RST_VOLUME_STEP;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CLOCK_ENTITY:   r_clock_entity   <= i_cfg_data[7:0];
                CFG_FEATURE_ENTITY: r_feature_entity <= i_cfg_data[7:0];
                CFG_SAMPLE_RATE:    r_sample_rate    <= i_cfg_data;
                CFG_VOLUME_MIN:     r_volume_min     <= i_cfg_data[15:0];
                CFG_VOLUME_MAX:     r_volume_max     <= i_cfg_data[15:0];
                CFG_VOLUME_STEP:    r_volume_step    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
    end

    assign w_ch_ok = (r_req.channel_number <= 8'(CHANNELS));
    assign w_ch    = r_req.channel_number[CH_W-1:0];

    // request decode
    always_comb begin
        w_kind = K_STALL;
        if (r_req.func == FUNC_GET) begin
            if (r_req.entity_id == r_clock_entity) begin
                if (r_req.control_selector == SEL_FREQ && r_req.request_code == REQ_CUR) begin
                    w_kind = K_CLK_CUR;
                end else if (r_req.control_selector == SEL_FREQ
                             && r_req.request_code == REQ_RANGE) begin
                    w_kind = K_CLK_RANGE;
                end else if (r_req.control_selector == SEL_VALID
                             && r_req.request_code == REQ_CUR) begin
                    w_kind = K_CLK_VALID;
                end
            end else if (r_req.entity_id == r_feature_entity) begin
                if (r_req.control_selector == SEL_MUTE && r_req.request_code == REQ_CUR
                    && w_ch_ok) begin
                    w_kind = K_MUTE_CUR;
                end else if (r_req.control_selector == SEL_VOLUME
                             && r_req.request_code == REQ_RANGE) begin
                    w_kind = K_VOL_RANGE;
                end else if (r_req.control_selector == SEL_VOLUME
                             && r_req.request_code == REQ_CUR && w_ch_ok) begin
                    w_kind = K_VOL_CUR;
                end
            end
        end else if (r_req.entity_id == r_feature_entity && r_req.request_code == REQ_CUR
                     && w_ch_ok) begin
            if (r_req.control_selector == SEL_MUTE && r_req.data_length == LEN_MUTE) begin
                w_kind = K_SET_MUTE;
            end else if (r_req.control_selector == SEL_VOLUME
                         && r_req.data_length == LEN_VOLUME) begin
                w_kind = K_SET_VOL;
            end
        end
    end

    // store read and set commit; entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_mute_rd <= r_mute_vld[w_ch] ? mute_mem[w_ch] : 8'd0;
            r_vol_rd  <= r_vol_vld[w_ch]  ? vol_mem[w_ch]  : 16'd0;
            if (w_kind == K_SET_MUTE) begin
                mute_mem[w_ch] <= r_req.set_data[7:0];
            end
            if (w_kind == K_SET_VOL) begin
                vol_mem[w_ch] <= r_req.set_data;
            end
        end
    end

    // store valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mute_vld <= '0;
            r_vol_vld  <= '0;
        end else if (i_cmd.read) begin
            if (w_kind == K_SET_MUTE) begin
                r_mute_vld[w_ch] <= 1'b1;
            end
            if (w_kind == K_SET_VOL) begin
                r_vol_vld[w_ch] <= 1'b1;
            end
        end
    end

    // reply bytes, little-endian, byte k at bits 8k
    always_comb begin
        w_buf = '0;
        case (w_kind)
            K_CLK_CUR:   w_buf[31:0] = r_sample_rate;
            K_CLK_RANGE: w_buf[111:0] = {32'd0, r_sample_rate, r_sample_rate, 16'd1};
            K_CLK_VALID: w_buf[7:0] = 8'd1;
            K_MUTE_CUR:  w_buf[7:0] = r_mute_rd;
            K_VOL_CUR:   w_buf[15:0] = r_vol_rd;
            K_VOL_RANGE: w_buf[63:0] = {r_volume_step, r_volume_max, r_volume_min, 16'd1};
            default:     w_buf = '0;
        endcase
    end

    assign w_len = kind_len(w_kind);
    assign w_sel = i_cmd.build ? '0 : r_idx;

    // result for the selected byte
    always_comb begin
        w_rsp.last = (w_sel == w_len - BYTE_IDX_W'(1));
        case (w_kind)
            K_STALL: begin
                w_rsp.status     = ST_STALL;
                w_rsp.reply_byte = 8'd0;
            end
            K_SET_MUTE, K_SET_VOL: begin
                w_rsp.status     = ST_OK;
                w_rsp.reply_byte = 8'd0;
            end
            default: begin
                w_rsp.status     = ST_BYTE;
                w_rsp.reply_byte = w_buf[w_sel*8 +: 8];
            end
        endcase
    end

    // output register and byte counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.build || i_cmd.next) begin
            r_rsp <= w_rsp;
            r_idx <= w_sel + BYTE_IDX_W'(1);
        end
    end

    assign o_rsp       = r_rsp;
    assign o_stat.last = r_rsp.last;

endmodule

### rtl/core/uac2_control_request_responder.sv
// uac2 control request responder: one request accepted when idle, replies one result a cycle while i_rsp_ready is high
// first result: the request capture, the store read (S_READ) and the result load (S_LOAD) are registered in turn
// a new request is accepted only after the last result of the current one has been taken
// reset: synchronous active low; config returns to defaults, mute and volume stores read as zero
// depends on uac2_pkg, uac2_ctrl and uac2_dp
module uac2_control_request_responder import uac2_pkg::*; #(
    parameter int unsigned CHANNELS = DEF_CHANNELS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    output logic                 o_req_ready,
    input  t_req                 i_req,
    output logic                 o_rsp_valid,
    input  logic                 i_rsp_ready,
    output t_rsp                 o_rsp,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // config writes are always taken
    assign o_cfg_ready = 1'b1;

    // sequencer
    uac2_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // datapath
    uac2_dp #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req       (i_req),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_rsp       (o_rsp)
    );

endmodule

### dv/tb_top.sv
// self-checking testbench for the uac2 control request responder
// depends on uac2_pkg and rtl/core/uac2_control_request_responder.sv
`timescale 1ns / 1ps

module tb_top;
    import uac2_pkg::*;

    localparam int unsigned TB_CHANNELS = DEF_CHANNELS;
    localparam logic        FUNC_SET    = 1'b1;
    localparam int          HOLD_CYCLES = 80;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          STALL_LIMIT = 2000;
    localparam int          RANDOM_PER_PHASE = 70;

    // one directed row: request plus an optional hand-typed reply
    typedef struct {
        t_req        req;
        logic [1:0]  st;
        logic [31:0] val;
        int          nres;   // 0: reply comes from the predictor
    } t_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_req_valid;
    logic                 o_req_ready;
    t_req                 i_req;
    logic                 o_rsp_valid;
    logic                 i_rsp_ready;
    t_rsp                 o_rsp;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0]          i_cfg_data;

    // predictor copy of configuration and channel stores
    logic [7:0]  mirror_clock_ent;
    logic [7:0]  mirror_feature_ent;
    logic [31:0] mirror_rate;
    logic [15:0] mirror_vol_min;
    logic [15:0] mirror_vol_max;
    logic [15:0] mirror_vol_step;
    logic [7:0]  mirror_mute [TB_CHANNELS+1];
    logic [15:0] mirror_volume [TB_CHANNELS+1];

    t_rsp pending_replies[$];
    t_row directed_rows[$];
    int   error_count = 0;
    int   quiet_cycles = 0;
    bit   quiet_tail = 1'b0;
    bit   hold_off_req = 1'b0;

    uac2_control_request_responder #(.CHANNELS(TB_CHANNELS)) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic note_mismatch(input string what);
        error_count++;
        $display("mismatch at %0t ns: %s", $realtime, what);
    endtask

    // predicted replies of one request, updates the channel stores on a set
    function automatic void answer_request(input t_req r, ref t_rsp replies[$]);
        logic [7:0] b [REPLY_BYTES];
        logic [1:0] st;
        t_rsp       one;
        int         n;
        bit         ch_ok;
        replies.delete();
        n = 0;
        st = ST_STALL;
        ch_ok = r.channel_number <= TB_CHANNELS;
        if (r.func == FUNC_GET) begin
            if (r.entity_id == mirror_clock_ent) begin
                if (r.control_selector == SEL_FREQ && r.request_code == REQ_CUR) begin
                    {b[3], b[2], b[1], b[0]} = mirror_rate;
                    n = 4;
                end else if (r.control_selector == SEL_FREQ && r.request_code == REQ_RANGE) begin
                    {b[1], b[0]} = 16'd1;
                    {b[5], b[4], b[3], b[2]} = mirror_rate;
                    {b[9], b[8], b[7], b[6]} = mirror_rate;
                    {b[13], b[12], b[11], b[10]} = 32'd0;
                    n = 14;
                end else if (r.control_selector == SEL_VALID && r.request_code == REQ_CUR) begin
                    b[0] = 8'd1;
                    n = 1;
                end
            end else if (r.entity_id == mirror_feature_ent) begin
                if (r.control_selector == SEL_MUTE && r.request_code == REQ_CUR && ch_ok) begin
                    b[0] = mirror_mute[r.channel_number];
                    n = 1;
                end else if (r.control_selector == SEL_VOLUME
                             && r.request_code == REQ_RANGE) begin
                    {b[1], b[0]} = 16'd1;
                    {b[3], b[2]} = mirror_vol_min;
                    {b[5], b[4]} = mirror_vol_max;
                    {b[7], b[6]} = mirror_vol_step;
                    n = 8;
                end else if (r.control_selector == SEL_VOLUME
                             && r.request_code == REQ_CUR && ch_ok) begin
                    {b[1], b[0]} = mirror_volume[r.channel_number];
                    n = 2;
                end
            end
        end else if (r.entity_id == mirror_feature_ent && r.request_code == REQ_CUR && ch_ok) begin
            if (r.control_selector == SEL_MUTE && r.data_length == LEN_MUTE) begin
                mirror_mute[r.channel_number] = r.set_data[7:0];
                st = ST_OK;
            end else if (r.control_selector == SEL_VOLUME && r.data_length == LEN_VOLUME) begin
                mirror_volume[r.channel_number] = r.set_data;
                st = ST_OK;
            end
        end
        if (n == 0) begin
            one = {st, 8'd0, 1'b1};
            replies.push_back(one);
        end else begin
            for (int k = 0; k < n; k++) begin
                one = {ST_BYTE, b[k], (k == n - 1)};
                replies.push_back(one);
            end
        end
    endfunction

    // mostly well-formed requests aimed at the configured entities, some noise
    function automatic t_req random_request();
        t_req r;
        int   pick;
        r = {$urandom, $urandom, 1'($urandom)};
        if ($urandom_range(0, 9) != 0) begin
            pick = $urandom_range(0, 19);
            if (pick < 9) begin
                r.entity_id = mirror_clock_ent;
            end else if (pick < 18) begin
                r.entity_id = mirror_feature_ent;
            end
            if ($urandom_range(0, 15) != 0) begin
                r.control_selector = $urandom_range(0, 1) ? SEL_MUTE : SEL_VOLUME;
            end
            if ($urandom_range(0, 15) != 0) begin
                if (r.func == FUNC_GET) begin
                    r.request_code = $urandom_range(0, 1) ? REQ_CUR : REQ_RANGE;
                end else begin
                    r.request_code = REQ_CUR;
                end
            end
            if ($urandom_range(0, 7) != 0) begin
                r.channel_number = 8'($urandom_range(0, TB_CHANNELS));
            end
            if (r.func == FUNC_SET && $urandom_range(0, 7) != 0) begin
                r.data_length = (r.control_selector == SEL_MUTE) ? LEN_MUTE : LEN_VOLUME;
            end
        end
        return r;
    endfunction

    task automatic add_row(input logic f, input logic [7:0] ent, input logic [7:0] sel,
                           input logic [7:0] code, input logic [7:0] ch,
                           input logic [15:0] len, input logic [15:0] data,
                           input logic [1:0] st, input logic [31:0] val, input int nres);
        t_row row;
        row.req = {f, ent, sel, code, ch, len, data};
        row.st = st;
        row.val = val;
        row.nres = nres;
        directed_rows.push_back(row);
    endtask

    // offer one request, then queue its replies once it is taken
    task automatic send_request(input t_row row);
        t_rsp replies[$];
        t_rsp one;
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            i_req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_req <= row.req;
        i_req_valid <= 1'b1;
        do @(posedge i_clk); while (!o_req_ready);
        answer_request(row.req, replies);
        if (row.nres != 0) begin
            replies.delete();
            if (row.st == ST_BYTE) begin
                for (int k = 0; k < row.nres; k++) begin
                    one = {ST_BYTE, row.val[8*k +: 8], (k == row.nres - 1)};
                    replies.push_back(one);
                end
            end else begin
                one = {row.st, 8'd0, 1'b1};
                replies.push_back(one);
            end
        end
        foreach (replies[k]) pending_replies.push_back(replies[k]);
    endtask

    // write all six registers back to back, valid held high across them
    task automatic write_settings(input logic [7:0] clock_ent, input logic [7:0] feature_ent,
                                  input logic [31:0] rate, input logic [15:0] vol_min,
                                  input logic [15:0] vol_max, input logic [15:0] vol_step);
        logic [CFG_IDX_W-1:0] idx [6];
        logic [31:0]          vals [6];
        idx[0] = CFG_CLOCK_ENTITY;   vals[0] = {24'd0, clock_ent};
        idx[1] = CFG_FEATURE_ENTITY; vals[1] = {24'd0, feature_ent};
        idx[2] = CFG_SAMPLE_RATE;    vals[2] = rate;
        idx[3] = CFG_VOLUME_MIN;     vals[3] = {16'd0, vol_min};
        idx[4] = CFG_VOLUME_MAX;     vals[4] = {16'd0, vol_max};
        idx[5] = CFG_VOLUME_STEP;    vals[5] = {16'd0, vol_step};
        for (int i = 0; i < 6; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data <= vals[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (idx[i])
                CFG_CLOCK_ENTITY:   mirror_clock_ent = vals[i][7:0];
                CFG_FEATURE_ENTITY: mirror_feature_ent = vals[i][7:0];
                CFG_SAMPLE_RATE:    mirror_rate = vals[i];
                CFG_VOLUME_MIN:     mirror_vol_min = vals[i][15:0];
                CFG_VOLUME_MAX:     mirror_vol_max = vals[i][15:0];
                CFG_VOLUME_STEP:    mirror_vol_step = vals[i][15:0];
                default: ;
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // reply receiver: random back-pressure bursts plus one long hold-off
    initial begin
        i_rsp_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                i_rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
            i_rsp_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // reply checker
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
            if (pending_replies.size() == 0) begin
                note_mismatch($sformatf("reply %0h with no request waiting", o_rsp));
            end else begin
                want = pending_replies.pop_front();
                if (o_rsp.status !== want.status) begin
                    note_mismatch($sformatf("status %0d, want %0d", o_rsp.status, want.status));
                end
                if (o_rsp.reply_byte !== want.reply_byte) begin
                    note_mismatch($sformatf("reply byte %02h, want %02h",
                                            o_rsp.reply_byte, want.reply_byte));
                end
                if (o_rsp.last !== want.last) begin
                    note_mismatch($sformatf("last %0b, want %0b", o_rsp.last, want.last));
                end
            end
        end
    end

    // watchdog on cycles with no handshake on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles < STALL_LIMIT) begin
            quiet_cycles <= quiet_cycles + 1;
        end else begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // main sequence
    initial begin
        t_row row;
        logic [7:0] rnd_clock;
        i_rst_n <= 1'b0;
        i_req_valid <= 1'b0;
        i_req <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_CLOCK_ENTITY;
        i_cfg_data <= '0;
        mirror_clock_ent = RST_CLOCK_ENTITY;
        mirror_feature_ent = RST_FEATURE_ENTITY;
        mirror_rate = RST_SAMPLE_RATE;
        mirror_vol_min = RST_VOLUME_MIN;
        mirror_vol_max = RST_VOLUME_MAX;
        mirror_vol_step = RST_VOLUME_STEP;
        for (int i = 0; i <= TB_CHANNELS; i++) begin
            mirror_mute[i] = 8'd0;
            mirror_volume[i] = 16'd0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed requests at reset settings
        add_row(FUNC_GET, RST_CLOCK_ENTITY, SEL_FREQ, REQ_CUR, 8'd0, 16'd0, 16'd0,
                ST_BYTE, 32'd48000, 4);
        add_row(FUNC_GET, RST_CLOCK_ENTITY, SEL_FREQ, REQ_RANGE, 8'd0, 16'd0, 16'd0,
                ST_BYTE, 32'd0, 0);
        add_row(FUNC_GET, RST_CLOCK_ENTITY, SEL_VALID, REQ_CUR, 8'd0, 16'd0, 16'd0,
                ST_BYTE, 32'd1, 1);
        add_row(FUNC_GET, RST_FEATURE_ENTITY, SEL_MUTE, REQ_CUR, 8'd0, 16'd0, 16'd0,
                ST_BYTE, 32'd0, 1);
        add_row(FUNC_GET, RST_FEATURE_ENTITY, SEL_VOLUME, REQ_CUR, 8'd2, 16'd0, 16'd0,
                ST_BYTE, 32'd0, 2);
        add_row(FUNC_GET, RST_FEATURE_ENTITY, SEL_VOLUME, REQ_RANGE, 8'hFF, 16'd0, 16'd0,
                ST_BYTE, 32'd0, 0);
        add_row(FUNC_GET, RST_FEATURE_ENTITY, SEL_MUTE, REQ_RANGE, 8'd0, 16'd0, 16'd0,
                ST_STALL, 32'd0, 1);
        add_row(FUNC_SET, RST_FEATURE_ENTITY, SEL_MUTE, REQ_CUR, 8'd1, LEN_MUTE, 16'hFFA5,
                ST_OK, 32'd0, 1);
        add_row(FUNC_GET, RST_FEATURE_ENTITY, SEL_MUTE, REQ_CUR, 8'd1, 16'd0, 16'd0,
                ST_BYTE, 32'd0, 0);
        add_row(FUNC_SET, RST_FEATURE_ENTITY, SEL_VOLUME, REQ_CUR, 8'd2, LEN_VOLUME, 16'h8000,
                ST_OK, 32'd0, 1);
        add_row(FUNC_GET, RST_FEATURE_ENTITY, SEL_VOLUME, REQ_CUR, 8'd2, 16'd0, 16'd0,
                ST_BYTE, 32'd0, 0);
        add_row(FUNC_SET, RST_FEATURE_ENTITY, SEL_VOLUME, REQ_CUR, 8'd0, LEN_VOLUME, 16'hFFFF,
                ST_OK, 32'd0, 1);
        add_row(FUNC_GET, RST_FEATURE_ENTITY, SEL_VOLUME, REQ_CUR, 8'd0, 16'd0, 16'd0,
                ST_BYTE, 32'd0, 0);
        // wrong lengths leave the stores alone
        add_row(FUNC_SET, RST_FEATURE_ENTITY, SEL_MUTE, REQ_CUR, 8'd0, LEN_VOLUME, 16'h0001,
                ST_STALL, 32'd0, 1);
        add_row(FUNC_SET, RST_FEATURE_ENTITY, SEL_VOLUME, REQ_CUR, 8'd1, LEN_MUTE, 16'h1234,
                ST_STALL, 32'd0, 1);
        add_row(FUNC_SET, RST_FEATURE_ENTITY, SEL_VOLUME, REQ_CUR, 8'd1, 16'hFFFF, 16'h0000,
                ST_STALL, 32'd0, 1);
        // set to the clock, set with range code, channel out of range
        add_row(FUNC_SET, RST_CLOCK_ENTITY, SEL_FREQ, REQ_CUR, 8'd0, 16'd4, 16'h5555,
                ST_STALL, 32'd0, 1);
        add_row(FUNC_SET, RST_FEATURE_ENTITY, SEL_MUTE, REQ_RANGE, 8'd0, LEN_MUTE, 16'h0001,
                ST_STALL, 32'd0, 1);
        add_row(FUNC_SET, RST_FEATURE_ENTITY, SEL_MUTE, REQ_CUR, 8'd3, LEN_MUTE, 16'h0001,
                ST_STALL, 32'd0, 1);
        add_row(FUNC_GET, RST_FEATURE_ENTITY, SEL_MUTE, REQ_CUR, 8'd3, 16'd0, 16'd0,
                ST_STALL, 32'd0, 1);
        add_row(FUNC_GET, RST_FEATURE_ENTITY, SEL_VOLUME, REQ_CUR, 8'hFF, 16'd0, 16'd0,
                ST_STALL, 32'd0, 1);
        // unknown entity, selector and request code
        add_row(FUNC_GET, 8'h00, SEL_FREQ, REQ_CUR, 8'd0, 16'd0, 16'd0, ST_STALL, 32'd0, 1);
        add_row(FUNC_GET, 8'hFF, SEL_FREQ, REQ_CUR, 8'd0, 16'd0, 16'd0, ST_STALL, 32'd0, 1);
        add_row(FUNC_GET, RST_FEATURE_ENTITY, 8'h00, REQ_CUR, 8'd0, 16'd0, 16'd0,
                ST_STALL, 32'd0, 1);
        add_row(FUNC_GET, RST_CLOCK_ENTITY, 8'hFF, REQ_CUR, 8'd0, 16'd0, 16'd0,
                ST_STALL, 32'd0, 1);
        add_row(FUNC_GET, RST_FEATURE_ENTITY, SEL_VOLUME, 8'hFF, 8'd1, 16'd0, 16'd0,
                ST_STALL, 32'd0, 1);
        add_row(FUNC_GET, RST_FEATURE_ENTITY, SEL_VOLUME, REQ_CUR, 8'd1, 16'd0, 16'd0,
                ST_BYTE, 32'd0, 0);
        foreach (directed_rows[i]) send_request(directed_rows[i]);

        // random phases, each under its own settings
        for (int phase = 0; phase < 5; phase++) begin
            i_req_valid <= 1'b0;
            drain();
            case (phase)
                0: write_settings(8'h00, 8'hFF, 32'hFFFF_FFFF, 16'h8000, 16'h7FFF, 16'hFFFF);
                1: write_settings(8'hFF, 8'h00, 32'd0, 16'h7FFF, 16'h8000, 16'h0000);
                2: write_settings(8'd7, 8'd7, 32'd44100, 16'hF000, 16'h0100, 16'd128);
                3: begin
                    rnd_clock = 8'($urandom);
                    write_settings(rnd_clock, rnd_clock + 8'($urandom_range(1, 255)),
                                   $urandom, 16'($urandom), 16'($urandom), 16'($urandom));
                end
                default: write_settings(RST_CLOCK_ENTITY, RST_FEATURE_ENTITY, RST_SAMPLE_RATE,
                                        RST_VOLUME_MIN, RST_VOLUME_MAX, RST_VOLUME_STEP);
            endcase
            // long receiver hold-off in the first phase, no idling in the last
            if (phase == 0) hold_off_req = 1'b1;
            if (phase == 4) quiet_tail = 1'b1;
            for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
                row.req = random_request();
                row.st = ST_BYTE;
                row.val = 32'd0;
                row.nres = 0;
                send_request(row);
            end
        end
        i_req_valid <= 1'b0;
        drain();

        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
